// ----- hw/rtl/amh_pkg.sv -----
// Package for the AES-128 Matyas-Meyer-Oseas hash core: constants and AES helper functions.
package amh_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned DataW      = 8;
  localparam int unsigned DigestW    = 64;
  localparam int unsigned NumRounds  = 10;

  // AES forward substitution box
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
    return w[127-8*i -: 8];
  endfunction

  // One AES round without the key addition: SubBytes, ShiftRows, optional MixColumns
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic mix);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127-8*(4*c+i) -: 8] = sbox(get_byte(s, 4*((c+i)%4)+i));
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(t, 4*c);
        a1 = get_byte(t, 4*c+1);
        a2 = get_byte(t, 4*c+2);
        a3 = get_byte(t, 4*c+3);
        all = a0 ^ a1 ^ a2 ^ a3;
        t[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
        t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
        t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
        t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    return t;
  endfunction

  // Next round key from the current one and its round constant
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tmp = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ tmp;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- hw/rtl/aes128_mmo_hash_core.sv -----
// Top level of the AES-128 Matyas-Meyer-Oseas hash core with an iterative round unit.
// A byte that does not close a block is only written into the block buffer.
// A byte that closes a block or the message adds the key in its accept cycle, then runs
// the ten AES rounds on one shared round unit; a last byte on a block boundary adds a
// second pass over an all-zero block. The digest moves to an output register; intake
// stalls while rounds run and while a finished digest finds the previous one still there.
// Reset clears the chaining value, block buffer, byte count, output register and control.
module aes128_mmo_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [127:0] m_axis_tdata   // [63:0] digest_high, [127:64] digest_low
);
  import amh_pkg::*;

  typedef enum logic [1:0] {StIdle, StRun, StOut} state_e;

  state_e       state_q;
  logic [3:0]   cnt_q;
  logic [3:0]   rnd_q;
  logic         again_q;
  logic         fin_q;
  logic [7:0]   rc_q;
  logic [127:0] h_q, m_q, s_q, k_q;
  logic [127:0] dig_q;
  logic         dig_vld_q;

  logic         acc, full;
  logic         dig_free, dig_load;
  logic [127:0] m_new, rf, kn, fin_h;

  assign acc  = s_axis_tvalid && s_axis_tready;
  assign full = (cnt_q == 4'(BlockBytes - 1));
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = dig_vld_q;
  assign m_axis_tdata  = {dig_q[63:0], dig_q[127:64]};

  always_comb begin
    m_new = m_q;
    m_new[127-8*cnt_q -: 8] = s_axis_tdata;
  end

  assign kn    = key_next(k_q, rc_q);
  assign rf    = round_fn(s_q, rnd_q != 4'(NumRounds));
  assign fin_h = rf ^ kn ^ m_q;

  // Load the output register when it is free or being emptied
  assign dig_free = !dig_vld_q || m_axis_tready;
  assign dig_load = dig_free && ((state_q == StOut) ||
                    (state_q == StRun && rnd_q == 4'(NumRounds) && fin_q && !again_q));

  // Sequence byte intake, AES rounds and digest delivery
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      rnd_q     <= '0;
      again_q   <= 1'b0;
      fin_q     <= 1'b0;
      rc_q      <= 8'h01;
      h_q       <= '0;
      m_q       <= '0;
      s_q       <= '0;
      k_q       <= '0;
      dig_q     <= '0;
      dig_vld_q <= 1'b0;
    end else begin
      // Hold the digest until its transaction completes
      if (dig_load) begin
        dig_q     <= (state_q == StOut) ? h_q : fin_h;
        dig_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        dig_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            cnt_q <= cnt_q + 4'd1;
            if (full || s_axis_tlast) begin
              m_q     <= m_new;
              s_q     <= m_new ^ h_q;
              k_q     <= h_q;
              rc_q    <= 8'h01;
              rnd_q   <= 4'd1;
              again_q <= full && s_axis_tlast;
              fin_q   <= s_axis_tlast;
              state_q <= StRun;
            end else begin
              m_q <= m_new;
            end
          end
        end
        StRun: begin
          if (rnd_q == 4'(NumRounds)) begin
            // feed forward the message block
            cnt_q <= '0;
            m_q   <= '0;
            if (again_q) begin
              again_q <= 1'b0;
              h_q     <= fin_h;
              s_q     <= fin_h;
              k_q     <= fin_h;
              rc_q    <= 8'h01;
              rnd_q   <= 4'd1;
            end else if (!fin_q) begin
              h_q     <= fin_h;
              state_q <= StIdle;
            end else if (dig_free) begin
              h_q     <= '0;
              state_q <= StIdle;
            end else begin
              h_q     <= fin_h;
              state_q <= StOut;
            end
          end else begin
            s_q   <= rf ^ kn;
            k_q   <= kn;
            rc_q  <= xtime(rc_q);
            rnd_q <= rnd_q + 4'd1;
          end
        end
        StOut: begin
          if (dig_free) begin
            h_q     <= '0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Digest holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("digest changed under stall");
  // Valid holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("digest dropped under stall");
  // Round counter stays in range while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> rnd_q >= 4'd1 && rnd_q <= 4'(NumRounds))
    else $error("round count out of range");
  // Block buffer is empty whenever the byte count is zero in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle && cnt_q == '0 |-> m_q == '0)
    else $error("stale block data");
  // Handing a digest to the output register clears the chaining value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_load |=> m_axis_tvalid && h_q == '0 && cnt_q == '0)
    else $error("chain not cleared after digest");

endmodule
